// ===== rtl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types, register indexes and saturation helper for the box push-out
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   gap_t;
  typedef logic        [COORD_W:0]   mag_t;
  typedef logic signed [COORD_W+1:0] wide_t;

  // reset offsets of the mover box
  localparam coord_t OFF_MIN_XY_RST = coord_t'(-(25 << FRAC_BITS));
  localparam coord_t OFF_MIN_Z_RST  = coord_t'(-(220 << FRAC_BITS));
  localparam coord_t OFF_MAX_XY_RST = coord_t'(25 << FRAC_BITS);
  localparam coord_t OFF_MAX_Z_RST  = coord_t'((401 << FRAC_BITS) >> 1);

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    CFG_OFF_MIN_X = 3'd0,
    CFG_OFF_MIN_Y = 3'd1,
    CFG_OFF_MIN_Z = 3'd2,
    CFG_OFF_MAX_X = 3'd3,
    CFG_OFF_MAX_Y = 3'd4,
    CFG_OFF_MAX_Z = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic   frame_start;
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t obst_min_x;
    coord_t obst_min_y;
    coord_t obst_min_z;
    coord_t obst_max_x;
    coord_t obst_max_y;
    coord_t obst_max_z;
  } in_beat_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   overlap;
    axis_t  push_axis;
    logic   landed;
  } out_beat_t;

  // clamp a widened sum back into the coordinate range
  function automatic coord_t sat_sum(wide_t s);
    coord_t r;
    if ((s[COORD_W+1] == s[COORD_W]) && (s[COORD_W] == s[COORD_W-1])) begin
      r = s[COORD_W-1:0];
    end else if (s[COORD_W+1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/aabb_mover_box.sv =====
// ----------------------------------------------------------------------------
// aabb_mover_box
// mover box edges: position plus corner offsets, saturated per edge
// ----------------------------------------------------------------------------
module aabb_mover_box (
  input  aabb_pkg::vec_t pos,
  input  aabb_pkg::box_t offs,
  output aabb_pkg::box_t edges
);
  import aabb_pkg::*;

  function automatic coord_t edge_of(coord_t p, coord_t o);
    wide_t s;
    s = wide_t'(p) + wide_t'(o);
    return sat_sum(s);
  endfunction

  always_comb begin
    edges.min_x = edge_of(pos.x, offs.min_x);
    edges.min_y = edge_of(pos.y, offs.min_y);
    edges.min_z = edge_of(pos.z, offs.min_z);
    edges.max_x = edge_of(pos.x, offs.max_x);
    edges.max_y = edge_of(pos.y, offs.max_y);
    edges.max_z = edge_of(pos.z, offs.max_z);
  end

endmodule

// ===== rtl/aabb_resolve.sv =====
// ----------------------------------------------------------------------------
// aabb_resolve
// overlap test, per-axis gap, least-gap axis pick and position update
// ----------------------------------------------------------------------------
module aabb_resolve (
  input  aabb_pkg::vec_t    pos,
  input  logic              landed_in,
  input  aabb_pkg::box_t    mover,
  input  aabb_pkg::box_t    obst,
  output aabb_pkg::out_beat_t res
);
  import aabb_pkg::*;

  function automatic mag_t mag_of(gap_t g);
    gap_t n;
    n = -g;
    return g[COORD_W] ? mag_t'(n) : mag_t'(g);
  endfunction

  // smaller-magnitude gap, ties go to the obstacle-min side
  function automatic gap_t gap_of(coord_t mn, coord_t mx, coord_t omn, coord_t omx);
    gap_t g1;
    gap_t g2;
    g1 = gap_t'(omx) - gap_t'(mn);
    g2 = gap_t'(omn) - gap_t'(mx);
    return (mag_of(g1) < mag_of(g2)) ? g1 : g2;
  endfunction

  function automatic coord_t move(coord_t p, gap_t d);
    wide_t s;
    s = wide_t'(p) + wide_t'(d);
    return sat_sum(s);
  endfunction

  logic hit;
  gap_t dx, dy, dz;
  mag_t ax, ay, az;

  always_comb begin
    // touching counts as overlap
    hit = !(mover.max_x < obst.min_x || mover.max_y < obst.min_y ||
            mover.max_z < obst.min_z || obst.max_x < mover.min_x ||
            obst.max_y < mover.min_y || obst.max_z < mover.min_z);

    dx = gap_of(mover.min_x, mover.max_x, obst.min_x, obst.max_x);
    dy = gap_of(mover.min_y, mover.max_y, obst.min_y, obst.max_y);
    dz = gap_of(mover.min_z, mover.max_z, obst.min_z, obst.max_z);
    ax = mag_of(dx);
    ay = mag_of(dy);
    az = mag_of(dz);

    res.pos_x     = pos.x;
    res.pos_y     = pos.y;
    res.pos_z     = pos.z;
    res.overlap   = hit;
    res.push_axis = AXIS_NONE;
    res.landed    = landed_in;

    if (hit) begin
      priority if (ax <= ay && ax <= az) begin
        res.pos_x     = move(pos.x, dx);
        res.push_axis = AXIS_X;
      end else if (ay <= ax && ay <= az) begin
        res.pos_y     = move(pos.y, dy);
        res.push_axis = AXIS_Y;
      end else begin
        res.pos_z     = move(pos.z, dz);
        res.push_axis = AXIS_Z;
        res.landed    = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/aabb_collision_push_out.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_push_out
// Pushes a moving axis-aligned box out of static obstacle boxes, one obstacle
// per input beat. A beat with frame_start set loads the start position and
// clears the landed flag before its own test. The mover box is the running
// position plus the six offset registers (signed Q15.8, 24 bits); edges and
// new positions saturate. On overlap, touching included, the position moves
// along the axis of least gap (ties x, then y, then z); a z push sets landed
// until the next frame start. Each beat yields exactly one result beat. An
// input beat is registered, resolved combinationally against the running
// position and written to the result register, so the block sustains one
// beat per clock while the result side does not stall; the running position
// feeds back through that combinational path, which sets the rate. The
// input stalls only while both registers hold a beat and the result side
// stalls. The block does not enforce the offset write rule that follows.
// Offsets must be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module aabb_collision_push_out (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  aabb_pkg::in_beat_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output aabb_pkg::out_beat_t out_data,
  // configuration
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  aabb_pkg::coord_t    cfg_data
);
  import aabb_pkg::*;

  // offset registers
  box_t      off_r;
  // running mover state
  vec_t      cur_r;
  logic      landed_r;
  // input register stage
  in_beat_t  in_r;
  logic      in_vld_r;
  // result register stage
  out_beat_t out_r;
  logic      out_vld_r;

  logic      advance;
  vec_t      pos_eff;
  logic      landed_eff;
  box_t      obst;
  box_t      mover;
  out_beat_t res;

  // the held beat moves on when the result register is empty or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // frame start overrides the running position and clears landed
  always_comb begin
    if (in_r.frame_start) begin
      pos_eff.x  = in_r.start_x;
      pos_eff.y  = in_r.start_y;
      pos_eff.z  = in_r.start_z;
      landed_eff = 1'b0;
    end else begin
      pos_eff    = cur_r;
      landed_eff = landed_r;
    end
    obst.min_x = in_r.obst_min_x;
    obst.min_y = in_r.obst_min_y;
    obst.min_z = in_r.obst_min_z;
    obst.max_x = in_r.obst_max_x;
    obst.max_y = in_r.obst_max_y;
    obst.max_z = in_r.obst_max_z;
  end

  aabb_mover_box u_mover_box (
    .pos   (pos_eff),
    .offs  (off_r),
    .edges (mover)
  );

  aabb_resolve u_resolve (
    .pos       (pos_eff),
    .landed_in (landed_eff),
    .mover     (mover),
    .obst      (obst),
    .res       (res)
  );

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r.min_x <= OFF_MIN_XY_RST;
      off_r.min_y <= OFF_MIN_XY_RST;
      off_r.min_z <= OFF_MIN_Z_RST;
      off_r.max_x <= OFF_MAX_XY_RST;
      off_r.max_y <= OFF_MAX_XY_RST;
      off_r.max_z <= OFF_MAX_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFF_MIN_X: off_r.min_x <= cfg_data;
        CFG_OFF_MIN_Y: off_r.min_y <= cfg_data;
        CFG_OFF_MIN_Z: off_r.min_z <= cfg_data;
        CFG_OFF_MAX_X: off_r.max_x <= cfg_data;
        CFG_OFF_MAX_Y: off_r.max_y <= cfg_data;
        CFG_OFF_MAX_Z: off_r.max_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // running position and landed flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      landed_r <= 1'b0;
    end else if (advance) begin
      cur_r.x  <= res.pos_x;
      cur_r.y  <= res.pos_y;
      cur_r.z  <= res.pos_z;
      landed_r <= res.landed;
    end
  end

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // input payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  // the result just written carries the running state it left behind
  a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_r.pos_x == cur_r.x && out_r.pos_y == cur_r.y &&
                 out_r.pos_z == cur_r.z && out_r.landed == landed_r))
    else $error("result beat does not match running state");

  // overlap and push axis agree
  a_overlap_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.overlap == (out_r.push_axis != AXIS_NONE)))
    else $error("overlap flag and push axis disagree");

  // a z push always reports landed
  a_z_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.push_axis == AXIS_Z) |-> out_r.landed)
    else $error("z push without landed");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_vld_r && out_stall && in_vld_r))
    else $error("input stalled with no waiting result");

endmodule
